### design/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared types and constants for the depth pixel back-projection pipeline.
// ----------------------------------------------------------------------------
package dpb_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int FIELD_W  = 12;
    localparam int DEPTH_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int RECIP_W  = 24;
    localparam int HALF_W   = 12;
    localparam int Z_W      = 31;
    localparam int PT_W     = 32;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 3;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 120;

    localparam logic [IDX_W-1:0] REG_DEPTH_SCALE = 3'd0;
    localparam logic [IDX_W-1:0] REG_FOCAL_X     = 3'd1;
    localparam logic [IDX_W-1:0] REG_FOCAL_Y     = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_X    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CENTER_Y    = 3'd4;

    localparam logic [RECIP_W-1:0] RECIP_RESET    = 24'd33554;
    localparam logic [FIELD_W-1:0] CENTER_X_RESET = 12'd300;
    localparam logic [FIELD_W-1:0] CENTER_Y_RESET = 12'd250;

    localparam logic [Z_W-1:0] Z_LIMIT = 31'h7FFF_FFFF;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

### design/dpb_lateral.sv
// ----------------------------------------------------------------------------
// dpb_lateral
// Four-stage pipeline for one lateral coordinate: offset from the principal
// point, scaling by z, scaling by the focal reciprocal, rounding, saturation.
// ----------------------------------------------------------------------------
module dpb_lateral
    import dpb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               aclk,
    input  stage_en_t          en,
    input  logic [FIELD_W-1:0] coord,
    input  logic [FIELD_W-1:0] center,
    input  logic [Z_W-1:0]     z_s1,
    input  logic [RECIP_W-1:0] recip,
    output logic [PT_W-1:0]    point
);

    localparam int CW    = COORD_BITS;
    localparam int P_W   = CW + Z_W;
    localparam int PP_W  = P_W + HALF_W;
    localparam int MAG_W = PP_W + 1 - HALF_W;

    logic [CW-1:0]    coord_m;
    logic [CW-1:0]    center_m;
    logic [CW-1:0]    dmag_reg, dmag_next;
    logic             neg1_reg, neg2_reg, neg3_reg;
    logic [P_W-1:0]   prod_reg, prod_next;
    logic [PP_W-1:0]  lo_reg, lo_next;
    logic [PP_W-1:0]  hi_reg, hi_next;
    logic [PP_W:0]    sum_lo;
    logic [PP_W:0]    sum_all;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] mag_sat;
    logic [PT_W-1:0]  point_reg, point_next;

    always_comb begin
        coord_m  = CW'(coord);
        center_m = CW'(center);
        if (coord_m < center_m) begin
            dmag_next = center_m - coord_m;
        end else begin
            dmag_next = coord_m - center_m;
        end
    end

    assign prod_next = P_W'(dmag_reg) * P_W'(z_s1);
    assign lo_next   = PP_W'(prod_reg) * PP_W'(recip[HALF_W-1:0]);
    assign hi_next   = PP_W'(prod_reg) * PP_W'(recip[RECIP_W-1:HALF_W]);

    always_comb begin
        sum_lo  = {1'b0, lo_reg} + ((PP_W+1)'(1) << (RECIP_W - 1));
        sum_all = {1'b0, hi_reg} + (sum_lo >> HALF_W);
        mag     = sum_all[PP_W:HALF_W];
        if (neg3_reg) begin
            mag_sat = (mag > MAG_W'(64'h8000_0000)) ? MAG_W'(64'h8000_0000) : mag;
            point_next = PT_W'(0) - mag_sat[PT_W-1:0];
        end else begin
            mag_sat = (mag > MAG_W'(64'h7FFF_FFFF)) ? MAG_W'(64'h7FFF_FFFF) : mag;
            point_next = mag_sat[PT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            dmag_reg <= dmag_next;
            neg1_reg <= (coord_m < center_m);
        end
        if (en.s2) begin
            prod_reg <= prod_next;
            neg2_reg <= neg1_reg;
        end
        if (en.s3) begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            neg3_reg <= neg2_reg;
        end
        if (en.s4) begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

### design/depth_pixel_backprojection.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Turns one RGB-D pixel into a 3-D point through a pinhole camera model.
// A beat is taken every clock cycle while s_tready is high, and its point
// passes through the four register stages of the multiplier chain (depth
// scaling, offset times z, the split focal product, then rounding and
// saturation). A pixel with zero depth is accepted and dropped. Each stage
// holds its beat while the stage after it is full and cannot advance, so
// back-pressure on the output fills bubbles first and then stalls the input.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection
    import dpb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,

    input  logic                s_tvalid,
    output logic                s_tready,
    // pixel_row, pixel_col, raw_depth, in_blue, in_green, in_red
    input  logic [S_DATA_W-1:0] s_tdata,

    output logic                m_tvalid,
    input  logic                m_tready,
    // point_x, point_y, point_z, out_blue, out_green, out_red, zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [RECIP_W-1:0] depth_scale_recip_reg;
    logic [RECIP_W-1:0] focal_x_recip_reg;
    logic [RECIP_W-1:0] focal_y_recip_reg;
    logic [FIELD_W-1:0] center_x_reg;
    logic [FIELD_W-1:0] center_y_reg;

    logic [FIELD_W-1:0] pixel_row;
    logic [FIELD_W-1:0] pixel_col;
    logic [DEPTH_W-1:0] raw_depth;
    logic [3*COLOR_W-1:0] color_in;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;
    stage_en_t en;

    logic [40:0]          z_prod;
    logic [32:0]          z_round;
    logic [Z_W-1:0]       z_next;
    logic [Z_W-1:0]       z1_reg, z2_reg, z3_reg, z4_reg;
    logic [3*COLOR_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg;
    logic [PT_W-1:0]      point_x;
    logic [PT_W-1:0]      point_y;

    assign pixel_row = s_tdata[11:0];
    assign pixel_col = s_tdata[23:12];
    assign raw_depth = s_tdata[39:24];
    assign color_in  = s_tdata[63:40];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_scale_recip_reg <= RECIP_RESET;
            focal_x_recip_reg     <= RECIP_RESET;
            focal_y_recip_reg     <= RECIP_RESET;
            center_x_reg          <= CENTER_X_RESET;
            center_y_reg          <= CENTER_Y_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEPTH_SCALE: depth_scale_recip_reg <= cfg_wdata;
                REG_FOCAL_X:     focal_x_recip_reg     <= cfg_wdata;
                REG_FOCAL_Y:     focal_y_recip_reg     <= cfg_wdata;
                REG_CENTER_X:    center_x_reg          <= cfg_wdata[FIELD_W-1:0];
                REG_CENTER_Y:    center_y_reg          <= cfg_wdata[FIELD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign r4 = !v4_reg || m_tready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;

    assign en.s1 = r1;
    assign en.s2 = r2;
    assign en.s3 = r3;
    assign en.s4 = r4;

    assign s_tready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= s_tvalid && (raw_depth != '0);
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
            if (r4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_comb begin
        z_prod  = 41'(raw_depth) * 41'(depth_scale_recip_reg) + 41'd128;
        z_round = z_prod[40:8];
        z_next  = (z_round > 33'(Z_LIMIT)) ? Z_LIMIT : z_round[Z_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            z1_reg <= z_next;
            c1_reg <= color_in;
        end
        if (en.s2) begin
            z2_reg <= z1_reg;
            c2_reg <= c1_reg;
        end
        if (en.s3) begin
            z3_reg <= z2_reg;
            c3_reg <= c2_reg;
        end
        if (en.s4) begin
            z4_reg <= z3_reg;
            c4_reg <= c3_reg;
        end
    end

    dpb_lateral #(
        .COORD_BITS(COORD_BITS)
    ) u_lateral_x (
        .aclk   (aclk),
        .en     (en),
        .coord  (pixel_col),
        .center (center_x_reg),
        .z_s1   (z1_reg),
        .recip  (focal_x_recip_reg),
        .point  (point_x)
    );

    dpb_lateral #(
        .COORD_BITS(COORD_BITS)
    ) u_lateral_y (
        .aclk   (aclk),
        .en     (en),
        .coord  (pixel_row),
        .center (center_y_reg),
        .z_s1   (z1_reg),
        .recip  (focal_y_recip_reg),
        .point  (point_y)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = {1'b0, c4_reg, z4_reg, point_y, point_x};

`ifndef ASSERT_OFF
    // A beat with zero depth must never enter the pipeline.
    a_zero_depth_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (raw_depth == '0)) |=> !v1_reg)
        else $error("zero-depth beat entered the pipeline");

    // A beat with nonzero depth must occupy the first stage.
    a_depth_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (raw_depth != '0)) |=> v1_reg)
        else $error("accepted beat was lost at the first stage");

    // A full third stage behind a stalled output must keep its beat.
    a_stage3_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && v4_reg && !m_tready) |=> (v3_reg && $stable(z3_reg)))
        else $error("third stage dropped a beat during a stall");
`endif

endmodule
